// ----- design/pst_pkg.sv -----
// shared types and codes for the process state tracker
`timescale 1ns / 1ps
package pst_pkg;

  localparam int ID_W    = 4;
  localparam int ACT_W   = 3;
  localparam int DEV_W   = 2;
  localparam int STATE_W = 3;
  localparam int CNT_W   = 5;
  localparam int NUM_DEV = 3;

  localparam logic [ACT_W-1:0] ACT_LOAD      = 3'd0;
  localparam logic [ACT_W-1:0] ACT_REQUEST   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_DISPATCH  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_TIMEOUT   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_SWAP_OUT  = 3'd4;
  localparam logic [ACT_W-1:0] ACT_SWAP_IN   = 3'd5;
  localparam logic [ACT_W-1:0] ACT_INTERRUPT = 3'd6;
  localparam logic [ACT_W-1:0] ACT_TERMINATE = 3'd7;

  localparam logic [DEV_W-1:0] DEV_DISK     = 2'd0;
  localparam logic [DEV_W-1:0] DEV_KEYBOARD = 2'd1;
  localparam logic [DEV_W-1:0] DEV_PRINTER  = 2'd2;

  localparam int QI_DISK     = 0;
  localparam int QI_KEYBOARD = 1;
  localparam int QI_PRINTER  = 2;

  localparam logic [STATE_W-1:0] ST_ABSENT       = 3'd0;
  localparam logic [STATE_W-1:0] ST_READY        = 3'd1;
  localparam logic [STATE_W-1:0] ST_RUNNING      = 3'd2;
  localparam logic [STATE_W-1:0] ST_BLOCKED      = 3'd3;
  localparam logic [STATE_W-1:0] ST_READY_SUSP   = 3'd4;
  localparam logic [STATE_W-1:0] ST_BLOCKED_SUSP = 3'd5;
  localparam logic [STATE_W-1:0] ST_TERMINATED   = 3'd6;

  typedef struct packed {
    logic [ACT_W-1:0]   action;
    logic [ID_W-1:0]    pid;
    logic [STATE_W-1:0] load_state;
    logic [NUM_DEV-1:0] dev_sel;
    logic               in_table;
    logic               is_intr;
  } cmd_t;

  typedef struct packed {
    logic push;
    logic probe;
    logic remove;
  } qctl_t;

endpackage

// ----- design/pst_if.sv -----
// request and result channel interfaces
`timescale 1ns / 1ps
interface pst_in_if;
  import pst_pkg::*;
  logic               valid;
  logic               ready;
  logic [ACT_W-1:0]   action;
  logic [ID_W-1:0]    process_id;
  logic [DEV_W-1:0]   device;
  logic [STATE_W-1:0] load_state;

  modport source (output valid, action, process_id, device, load_state, input ready);
  modport sink (input valid, action, process_id, device, load_state, output ready);
endinterface

interface pst_out_if;
  import pst_pkg::*;
  logic               valid;
  logic               ready;
  logic [ID_W-1:0]    event_process;
  logic [STATE_W-1:0] state_code;
  logic               known;
  logic [CNT_W-1:0]   disk_count;
  logic [CNT_W-1:0]   keyboard_count;
  logic [CNT_W-1:0]   printer_count;
  logic               queue_full;

  modport source (output valid, event_process, state_code, known, disk_count,
                  keyboard_count, printer_count, queue_full, input ready);
  modport sink (input valid, event_process, state_code, known, disk_count,
                keyboard_count, printer_count, queue_full, output ready);
endinterface

// ----- design/process_state_tracker.sv -----
// process state tracker top level
//
//   channel   dir  handshake          payload
//   in_req    in   valid/ready        action, process_id, device, load_state
//   out_res   out  valid/ready        event_process, state_code, known,
//                                     three queue counts, queue_full
//
// a request passes through the front's command queue before the back end takes it;
// interrupts take a match phase then a compact phase, all other actions take one
// the front holds two decoded requests, so input and result stall apart
// reset is synchronous; the state table clears in the reset cycle itself
// queue counts follow the fill registers, which move only when a result loads
`timescale 1ns / 1ps
module process_state_tracker #(
  parameter int MAX_PROCESSES = 16,
  parameter int QUEUE_DEPTH   = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  pst_in_if.sink    in_req,
  pst_out_if.source out_res
);
  import pst_pkg::*;

  localparam int FW = $clog2(QUEUE_DEPTH + 1);

  cmd_t               cmd;
  logic               cmd_valid;
  logic               cmd_pop;
  qctl_t              qctl [NUM_DEV];
  logic [FW-1:0]      qfill [NUM_DEV];
  logic [NUM_DEV-1:0] qfull;

  pst_front #(
    .MAX_PROCESSES (MAX_PROCESSES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop)
  );

  for (genvar k = 0; k < NUM_DEV; k++) begin : g_queue
    pst_wait_queue #(
      .DEPTH (QUEUE_DEPTH)
    ) u_queue (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (qctl[k]),
      .id    (cmd.pid),
      .fill  (qfill[k]),
      .full  (qfull[k])
    );
  end

  pst_back #(
    .MAX_PROCESSES (MAX_PROCESSES),
    .QUEUE_DEPTH   (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .qctl      (qctl),
    .qfill     (qfill),
    .qfull     (qfull),
    .out_res   (out_res)
  );

endmodule

// ----- design/pst_front.sv -----
// request decode and two-entry command queue
`timescale 1ns / 1ps
module pst_front #(
  parameter int MAX_PROCESSES = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  pst_in_if.sink        in_req,
  output pst_pkg::cmd_t cmd,
  output logic          cmd_valid,
  input  logic          cmd_pop
);
  import pst_pkg::*;

  cmd_t       cq_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  cmd_t       dec;
  logic       push;
  logic       pop;

  always_comb begin
    dec.action     = in_req.action;
    dec.pid        = in_req.process_id;
    dec.load_state = in_req.load_state;
    dec.in_table   = {5'd0, in_req.process_id} < 9'(MAX_PROCESSES);
    dec.is_intr    = (in_req.action == ACT_INTERRUPT);
    case (in_req.device)
      DEV_DISK:     dec.dev_sel = 3'b001;
      DEV_KEYBOARD: dec.dev_sel = 3'b010;
      DEV_PRINTER:  dec.dev_sel = 3'b100;
      default:      dec.dev_sel = 3'b000;
    endcase
  end

  assign in_req.ready = (cnt_r != 2'd2);
  assign push         = in_req.valid && in_req.ready;
  assign pop          = cmd_pop && cmd_valid;
  assign cmd_valid    = (cnt_r != 2'd0);
  assign cmd          = cq_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      cq_r[wr_ptr_r] <= dec;
    end
  end

endmodule

// ----- design/pst_wait_queue.sv -----
// one device wait queue with match and one-step compaction
`timescale 1ns / 1ps
module pst_wait_queue #(
  parameter int DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  pst_pkg::qctl_t             ctl,
  input  logic [pst_pkg::ID_W-1:0]   id,
  output logic [$clog2(DEPTH+1)-1:0] fill,
  output logic                       full
);
  import pst_pkg::*;

  localparam int FW = $clog2(DEPTH + 1);
  localparam logic [DEPTH-1:0] ONES = '1;

  logic [ID_W-1:0]  ent_r [DEPTH];
  logic [DEPTH-1:0] match_r;
  logic [DEPTH-1:0] thermo;
  logic [DEPTH-1:0] occupied;
  logic [FW-1:0]    fill_r, fill_nxt;
  logic             found;

  assign fill  = fill_r;
  assign full  = (fill_r == FW'(DEPTH));
  assign found = |match_r;

  // entries at and after the first match move forward
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      thermo[i]   = |(match_r & (ONES >> (DEPTH - 1 - i)));
      occupied[i] = (FW'(i) < fill_r);
    end
  end

  always_comb begin
    fill_nxt = fill_r;
    if (ctl.push && !full) begin
      fill_nxt = fill_r + FW'(1);
    end else if (ctl.remove && found) begin
      fill_nxt = fill_r - FW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.probe) begin
      for (int i = 0; i < DEPTH; i++) begin
        match_r[i] <= occupied[i] && (ent_r[i] == id);
      end
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_ent
    if (g < DEPTH - 1) begin : g_mid
      always_ff @(posedge clk) begin
        if (ctl.push && !full && fill_r == FW'(g)) begin
          ent_r[g] <= id;
        end else if (ctl.remove && thermo[g]) begin
          ent_r[g] <= ent_r[g+1];
        end
      end
    end else begin : g_last
      always_ff @(posedge clk) begin
        if (ctl.push && !full && fill_r == FW'(g)) begin
          ent_r[g] <= id;
        end
      end
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(DEPTH)) else $error("wait queue fill beyond depth");

  a_miss_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.remove && !found) |=> $stable(fill_r))
    else $error("remove without match changed fill");

  a_full_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.push && full) |=> $stable(fill_r))
    else $error("push into full queue changed fill");

endmodule

// ----- design/pst_back.sv -----
// state table, queue sequencing and result register
`timescale 1ns / 1ps
module pst_back #(
  parameter int MAX_PROCESSES = 16,
  parameter int QUEUE_DEPTH   = 16
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  pst_pkg::cmd_t                            cmd,
  input  logic                                     cmd_valid,
  output logic                                     cmd_pop,
  output pst_pkg::qctl_t                           qctl [pst_pkg::NUM_DEV],
  input  logic [$clog2(QUEUE_DEPTH+1)-1:0]         qfill [pst_pkg::NUM_DEV],
  input  logic [pst_pkg::NUM_DEV-1:0]              qfull,
  pst_out_if.source                                out_res
);
  import pst_pkg::*;

  localparam int FW      = $clog2(QUEUE_DEPTH + 1);
  localparam int TABLE_N = (MAX_PROCESSES < (1 << ID_W)) ? MAX_PROCESSES : (1 << ID_W);
  localparam int TW      = $clog2(TABLE_N);

  localparam logic BK_RUN   = 1'b0;
  localparam logic BK_MATCH = 1'b1;

  logic [STATE_W-1:0] tbl_r [TABLE_N];
  logic               st_r, st_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [ID_W-1:0]    res_pid_r;
  logic [STATE_W-1:0] res_state_r;
  logic               res_full_r;
  logic               slot_free;
  logic               exec;
  logic               probe;
  logic [TW-1:0]      idx;
  logic [STATE_W-1:0] cur;
  logic [STATE_W-1:0] nxt;
  logic [STATE_W-1:0] nxt_rep;
  logic               loaded;
  logic               is_req;
  logic [FW+CNT_W-1:0] fill_ext [NUM_DEV];

  assign slot_free = !out_valid_r || out_res.ready;
  assign probe     = cmd_valid && slot_free && cmd.is_intr && (st_r == BK_RUN);
  assign exec      = cmd_valid && slot_free && (!cmd.is_intr || st_r == BK_MATCH);
  assign cmd_pop   = exec;
  assign is_req    = (cmd.action == ACT_REQUEST);

  assign idx    = cmd.pid[TW-1:0];
  assign cur    = cmd.in_table ? tbl_r[idx] : ST_ABSENT;
  assign loaded = (cur != ST_ABSENT);

  always_comb begin
    nxt = cur;
    case (cmd.action)
      ACT_LOAD: nxt = cmd.load_state;
      ACT_REQUEST: begin
        if (loaded) nxt = ST_BLOCKED;
      end
      ACT_DISPATCH: begin
        if (loaded) nxt = ST_RUNNING;
      end
      ACT_TIMEOUT: begin
        if (loaded) nxt = ST_READY;
      end
      ACT_SWAP_OUT: begin
        if (cur == ST_READY) nxt = ST_READY_SUSP;
        else if (cur == ST_BLOCKED) nxt = ST_BLOCKED_SUSP;
      end
      ACT_SWAP_IN: begin
        if (cur == ST_READY_SUSP) nxt = ST_READY;
        else if (cur == ST_BLOCKED_SUSP) nxt = ST_BLOCKED;
      end
      ACT_INTERRUPT: begin
        if (cur == ST_BLOCKED_SUSP) nxt = ST_READY_SUSP;
        else if (cur == ST_BLOCKED) nxt = ST_READY;
      end
      ACT_TERMINATE: begin
        if (loaded) nxt = ST_TERMINATED;
      end
      default: nxt = cur;
    endcase
    nxt_rep = cmd.in_table ? nxt : ST_ABSENT;
  end

  always_comb begin
    for (int k = 0; k < NUM_DEV; k++) begin
      qctl[k].push   = exec && is_req && cmd.dev_sel[k];
      qctl[k].probe  = probe;
      qctl[k].remove = exec && cmd.is_intr;
      fill_ext[k]    = {{CNT_W{1'b0}}, qfill[k]};
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      BK_RUN:   if (probe) st_nxt = BK_MATCH;
      BK_MATCH: if (exec) st_nxt = BK_RUN;
      default:  st_nxt = BK_RUN;
    endcase
    if (exec) out_valid_nxt = 1'b1;
    else if (out_res.ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= BK_RUN;
      out_valid_r <= 1'b0;
      for (int i = 0; i < TABLE_N; i++) begin
        tbl_r[i] <= ST_ABSENT;
      end
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
      if (exec && cmd.in_table) begin
        tbl_r[idx] <= nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      res_pid_r   <= cmd.pid;
      res_state_r <= nxt_rep;
      res_full_r  <= is_req && |(cmd.dev_sel & qfull);
    end
  end

  // fills only move on the edge that loads a new result
  assign out_res.valid          = out_valid_r;
  assign out_res.event_process  = res_pid_r;
  assign out_res.state_code     = res_state_r;
  assign out_res.known          = (res_state_r != ST_ABSENT);
  assign out_res.queue_full     = res_full_r;
  assign out_res.disk_count     = fill_ext[QI_DISK][CNT_W-1:0];
  assign out_res.keyboard_count = fill_ext[QI_KEYBOARD][CNT_W-1:0];
  assign out_res.printer_count  = fill_ext[QI_PRINTER][CNT_W-1:0];

  a_match_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == BK_MATCH) |-> cmd_valid) else $error("match phase without command");

  a_intr_two_step: assert property (@(posedge clk) disable iff (!rst_n)
    (exec && cmd.is_intr) |-> (st_r == BK_MATCH))
    else $error("interrupt executed without probe");

endmodule

// ----- dv/pst_state_checker.sv -----
// channel monitor that tracks the process table and device queues and checks every result
`timescale 1ns / 1ps
module pst_state_checker #(
  parameter int QUEUE_DEPTH  = 16,
  parameter int MAX_REPORTED = 10
) (
  input  logic clk,
  input  logic rst_n,
  pst_in_if    in_req,
  pst_out_if   out_res,
  output int   fail_count,
  output int   pending_count,
  output int   report_count,
  output int   drop_count
);
  import pst_pkg::*;

  localparam int NUM_PROC = 2 ** ID_W;

  typedef struct packed {
    logic [ID_W-1:0]    pid;
    logic [STATE_W-1:0] state;
    logic               known;
    logic [CNT_W-1:0]   disk;
    logic [CNT_W-1:0]   keyboard;
    logic [CNT_W-1:0]   printer;
    logic               full;
  } state_report_t;

  logic [STATE_W-1:0] proc_state [NUM_PROC];
  logic [ID_W-1:0]    waiters [NUM_DEV][$];
  state_report_t      awaited_reports [$];

  int fails   = 0;
  int reports = 0;
  int drops   = 0;

  function automatic state_report_t track_event(input logic [ACT_W-1:0] act,
                                                input logic [ID_W-1:0] pid,
                                                input logic [DEV_W-1:0] dev,
                                                input logic [STATE_W-1:0] ls);
    logic [STATE_W-1:0] cur;
    logic [STATE_W-1:0] nxt;
    logic               dropped;
    int                 qi;
    state_report_t      rep;
    cur     = proc_state[pid];
    nxt     = cur;
    dropped = 1'b0;
    qi      = int'(dev);
    case (act)
      ACT_LOAD: nxt = ls;
      ACT_REQUEST: begin
        if (cur != ST_ABSENT) nxt = ST_BLOCKED;
        // device none touches no queue
        if (qi < NUM_DEV) begin
          if (waiters[qi].size() >= QUEUE_DEPTH) dropped = 1'b1;
          else waiters[qi].push_back(pid);
        end
      end
      ACT_DISPATCH: if (cur != ST_ABSENT) nxt = ST_RUNNING;
      ACT_TIMEOUT: if (cur != ST_ABSENT) nxt = ST_READY;
      ACT_SWAP_OUT: begin
        if (cur == ST_READY) nxt = ST_READY_SUSP;
        else if (cur == ST_BLOCKED) nxt = ST_BLOCKED_SUSP;
      end
      ACT_SWAP_IN: begin
        if (cur == ST_READY_SUSP) nxt = ST_READY;
        else if (cur == ST_BLOCKED_SUSP) nxt = ST_BLOCKED;
      end
      ACT_INTERRUPT: begin
        if (cur == ST_BLOCKED_SUSP) nxt = ST_READY_SUSP;
        else if (cur == ST_BLOCKED) nxt = ST_READY;
        // first occurrence leaves each queue, later entries move up
        for (int q = 0; q < NUM_DEV; q++) begin
          int hit;
          hit = -1;
          for (int i = 0; i < waiters[q].size(); i++) begin
            if (hit < 0 && waiters[q][i] == pid) hit = i;
          end
          if (hit >= 0) waiters[q].delete(hit);
        end
      end
      default: if (cur != ST_ABSENT) nxt = ST_TERMINATED;
    endcase
    proc_state[pid] = nxt;
    rep.pid      = pid;
    rep.state    = nxt;
    rep.known    = (nxt != ST_ABSENT);
    rep.disk     = CNT_W'(waiters[QI_DISK].size());
    rep.keyboard = CNT_W'(waiters[QI_KEYBOARD].size());
    rep.printer  = CNT_W'(waiters[QI_PRINTER].size());
    rep.full     = dropped;
    return rep;
  endfunction

  always @(posedge clk) begin
    state_report_t want;
    state_report_t got;
    if (!rst_n) begin
      for (int i = 0; i < NUM_PROC; i++) proc_state[i] = ST_ABSENT;
      for (int q = 0; q < NUM_DEV; q++) waiters[q].delete();
      awaited_reports.delete();
    end else begin
      if (out_res.valid && out_res.ready) begin
        got.pid      = out_res.event_process;
        got.state    = out_res.state_code;
        got.known    = out_res.known;
        got.disk     = out_res.disk_count;
        got.keyboard = out_res.keyboard_count;
        got.printer  = out_res.printer_count;
        got.full     = out_res.queue_full;
        if (awaited_reports.size() == 0) begin
          fails++;
          if (fails <= MAX_REPORTED)
            $display("unexpected result: pid %0d state %0d known %0d %s %0d/%0d/%0d full %0d",
                     got.pid, got.state, got.known, "counts", got.disk, got.keyboard,
                     got.printer, got.full);
        end else begin
          want = awaited_reports.pop_front();
          reports++;
          if (got.pid !== want.pid || got.state !== want.state || got.known !== want.known ||
              got.disk !== want.disk || got.keyboard !== want.keyboard ||
              got.printer !== want.printer || got.full !== want.full) begin
            fails++;
            if (fails <= MAX_REPORTED) begin
              $display("mismatch: expected pid %0d state %0d known %0d %s %0d/%0d/%0d %s %0d",
                       want.pid, want.state, want.known, "counts", want.disk,
                       want.keyboard, want.printer, "full", want.full);
              $display("          actual   pid %0d state %0d known %0d %s %0d/%0d/%0d %s %0d",
                       got.pid, got.state, got.known, "counts", got.disk, got.keyboard,
                       got.printer, "full", got.full);
            end
          end
        end
      end
      if (in_req.valid && in_req.ready) begin
        want = track_event(in_req.action, in_req.process_id, in_req.device, in_req.load_state);
        if (want.full) drops++;
        awaited_reports.push_back(want);
      end
    end
    fail_count    <= fails;
    pending_count <= awaited_reports.size();
    report_count  <= reports;
    drop_count    <= drops;
  end

endmodule

// ----- dv/tb_top.sv -----
// top of the process state tracker testbench: clock, reset, event stimulus and verdict
`timescale 1ns / 1ps
module tb_top;
  import pst_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int TOTAL_ITEMS = 1450;
  localparam int TAIL_CYCLES = 20;

  logic clk     = 1'b0;
  logic rst_n;
  logic idle_on = 1'b1;
  logic hold_go = 1'b0;
  int   sent    = 0;
  int   quiet   = 0;
  int   fails;
  int   pending;
  int   reports;
  int   drops;

  pst_in_if  in_req ();
  pst_out_if out_res ();

  process_state_tracker uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_res (out_res)
  );

  pst_state_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_req        (in_req),
    .out_res       (out_res),
    .fail_count    (fails),
    .pending_count (pending),
    .report_count  (reports),
    .drop_count    (drops)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic post_event(input logic [ACT_W-1:0] act, input logic [ID_W-1:0] pid,
                            input logic [DEV_W-1:0] dev, input logic [STATE_W-1:0] ls);
    while (idle_on && $urandom_range(0, 99) < 32) begin
      in_req.valid <= 1'b0;
      @(posedge clk);
    end
    in_req.valid      <= 1'b1;
    in_req.action     <= act;
    in_req.process_id <= pid;
    in_req.device     <= dev;
    in_req.load_state <= ls;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
    sent++;
  endtask

  // result side: random back-pressure while idle_on is set, plus one long hold-off on request
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    out_res.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        repeat (HOLD_CYCLES) begin
          out_res.ready <= 1'b0;
          @(posedge clk);
        end
      end
      out_res.ready <= idle_on ? ($urandom_range(0, 99) >= 32) : 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_req.valid && in_req.ready) || (out_res.valid && out_res.ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
      $display("FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    int               r;
    int               dv;
    bit               held;
    bit               paused;
    logic [ACT_W-1:0] act;
    logic [ID_W-1:0]  pid;
    held   = 1'b0;
    paused = 1'b0;
    rst_n             <= 1'b0;
    in_req.valid      <= 1'b0;
    in_req.action     <= '0;
    in_req.process_id <= '0;
    in_req.device     <= '0;
    in_req.load_state <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // lowest id through every suspend transition
    post_event(ACT_LOAD, '0, DEV_DISK, ST_READY);
    post_event(ACT_SWAP_OUT, '0, DEV_KEYBOARD, '1);
    post_event(ACT_SWAP_IN, '0, DEV_PRINTER, '1);
    post_event(ACT_DISPATCH, '0, DEV_DISK, '0);
    post_event(ACT_REQUEST, '0, DEV_DISK, '1);
    post_event(ACT_SWAP_OUT, '0, DEV_DISK, '0);
    post_event(ACT_SWAP_IN, '0, DEV_DISK, '0);
    post_event(ACT_SWAP_OUT, '0, DEV_DISK, '0);
    post_event(ACT_INTERRUPT, '0, DEV_DISK, '0);
    // highest id, repeated requests and a blocked interrupt
    post_event(ACT_LOAD, '1, '1, '1);
    post_event(ACT_REQUEST, '1, DEV_KEYBOARD, '0);
    post_event(ACT_REQUEST, '1, DEV_KEYBOARD, '0);
    post_event(ACT_REQUEST, '1, DEV_PRINTER, '0);
    post_event(ACT_INTERRUPT, '1, '1, '0);
    post_event(ACT_TIMEOUT, '1, '0, '0);
    post_event(ACT_TERMINATE, '1, '0, '0);
    post_event(ACT_REQUEST, '1, DEV_W'(NUM_DEV), '0);
    // unloaded process still moves the queues
    post_event(ACT_REQUEST, ID_W'(9), DEV_DISK, '0);
    post_event(ACT_DISPATCH, ID_W'(9), DEV_DISK, '0);
    post_event(ACT_INTERRUPT, ID_W'(9), DEV_DISK, '0);
    post_event(ACT_LOAD, '1, DEV_DISK, ST_ABSENT);
    post_event(ACT_LOAD, ID_W'(3), DEV_DISK, ST_RUNNING);
    post_event(ACT_SWAP_OUT, ID_W'(3), DEV_DISK, '0);
    post_event(ACT_LOAD, ID_W'(3), DEV_DISK, ST_TERMINATED);
    post_event(ACT_INTERRUPT, ID_W'(3), DEV_PRINTER, '0);

    while (sent < TOTAL_ITEMS) begin
      if (!held && sent >= 500) begin
        held    = 1'b1;
        hold_go = 1'b1;
      end
      if (!paused && sent >= 1000) begin
        paused = 1'b1;
        in_req.valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
      end
      idle_on = !(sent >= 700 && sent < 900);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          // lifecycle of one process
          pid = ID_W'($urandom);
          post_event(ACT_LOAD, pid, DEV_W'($urandom), STATE_W'($urandom_range(1, 7)));
          repeat ($urandom_range(3, 8)) begin
            r = $urandom_range(0, 99);
            if (r < 25) act = ACT_REQUEST;
            else if (r < 40) act = ACT_DISPATCH;
            else if (r < 52) act = ACT_TIMEOUT;
            else if (r < 67) act = ACT_SWAP_OUT;
            else if (r < 80) act = ACT_SWAP_IN;
            else if (r < 95) act = ACT_INTERRUPT;
            else act = ACT_TERMINATE;
            post_event(act, pid, DEV_W'($urandom), STATE_W'($urandom));
          end
        end
        6: begin
          // burst on one device that can overflow its queue
          dv = $urandom_range(0, NUM_DEV - 1);
          repeat ($urandom_range(14, 20))
            post_event(ACT_REQUEST, ID_W'($urandom), DEV_W'(dv), STATE_W'($urandom));
        end
        7: begin
          for (int p = 0; p < 2 ** ID_W; p++)
            post_event(ACT_INTERRUPT, ID_W'(p), DEV_W'($urandom), STATE_W'($urandom));
        end
        default: begin
          repeat ($urandom_range(1, 5))
            post_event(ACT_W'($urandom), ID_W'($urandom), DEV_W'($urandom),
                       STATE_W'($urandom));
        end
      endcase
    end
    in_req.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d events sent, %0d results checked, %0d requests dropped on full queues",
             sent, reports, drops);
    $display("covered transitions, lifecycles, queue bursts, a long hold-off and a drain pause");
    if (fails == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/pst_pkg.sv
design/pst_if.sv
design/pst_front.sv
design/pst_wait_queue.sv
design/pst_back.sv
design/process_state_tracker.sv
dv/pst_state_checker.sv
dv/tb_top.sv
